[sv/stream_find_replace_first_defines.svh]
// Assertion macros shared by the RTL files.
`ifndef STREAM_FIND_REPLACE_FIRST_DEFINES_SVH
`define STREAM_FIND_REPLACE_FIRST_DEFINES_SVH

// Check outside reset.
`define SFR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check at every edge, reset included.
`define SFR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/sfr_pkg.sv]
`default_nettype none

package sfr_pkg;

   localparam int PATTERN_MAX_DEF   = 8;
   localparam int REPLACE_MAX_DEF   = 8;
   localparam int POSITION_BITS_DEF = 16;

   // holds a length of 0..8
   localparam int COUNT_BITS    = 4;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;

   typedef enum logic [2:0] {
      REG_MATCH_PATTERN      = 3'd0,
      REG_PATTERN_LENGTH     = 3'd1,
      REG_REPLACEMENT        = 3'd2,
      REG_REPLACEMENT_LENGTH = 3'd3,
      REG_START_OFFSET       = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [63:0] match_pattern;
      logic [3:0]  pattern_length;
      logic [63:0] replacement;
      logic [3:0]  replacement_length;
      logic [15:0] start_offset;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic                  final_flag;
      logic                  closing;
      logic                  replaced;
      logic                  overflow;
   } burst_ctrl_type;

endpackage

`default_nettype wire

[sv/sfr_csr.sv]
`default_nettype none

module sfr_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [sfr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [sfr_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [sfr_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                     csr_pready,
   output sfr_pkg::cfg_type                         cfg
);
   import sfr_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:3]);
   assign csr_pready = 1'b1;
   assign write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            REG_MATCH_PATTERN:      cfg_in.match_pattern      = csr_pwdata;
            REG_PATTERN_LENGTH:     cfg_in.pattern_length     = csr_pwdata[3:0];
            REG_REPLACEMENT:        cfg_in.replacement        = csr_pwdata;
            REG_REPLACEMENT_LENGTH: cfg_in.replacement_length = csr_pwdata[3:0];
            REG_START_OFFSET:       cfg_in.start_offset       = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_MATCH_PATTERN:      csr_prdata = cfg_ff.match_pattern;
         REG_PATTERN_LENGTH:     csr_prdata = CSR_DATA_BITS'(cfg_ff.pattern_length);
         REG_REPLACEMENT:        csr_prdata = cfg_ff.replacement;
         REG_REPLACEMENT_LENGTH: csr_prdata = CSR_DATA_BITS'(cfg_ff.replacement_length);
         REG_START_OFFSET:       csr_prdata = CSR_DATA_BITS'(cfg_ff.start_offset);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_pattern      <= '0;
         cfg_ff.pattern_length     <= 4'd1;
         cfg_ff.replacement        <= '0;
         cfg_ff.replacement_length <= '0;
         cfg_ff.start_offset       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[sv/sfr_core.sv]
`default_nettype none
`include "stream_find_replace_first_defines.svh"

module sfr_core #(
   parameter  int PATTERN_MAX   = sfr_pkg::PATTERN_MAX_DEF,
   parameter  int REPLACE_MAX   = sfr_pkg::REPLACE_MAX_DEF,
   parameter  int POSITION_BITS = sfr_pkg::POSITION_BITS_DEF,
   localparam int BURST_MAX     = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sfr_pkg::cfg_type           cfg,
   input  wire logic [7:0]                 req_byte,
   input  wire logic                       req_last,
   input  wire logic                       advance,
   output sfr_pkg::burst_ctrl_type         next_ctrl,
   output logic      [7:0]                 next_bytes [BURST_MAX],
   output logic      [POSITION_BITS-1:0]   next_position,
   output logic      [POSITION_BITS:0]     next_length
);
   import sfr_pkg::*;

   localparam int CMP_BITS = (POSITION_BITS + 1 > 16) ? POSITION_BITS + 1 : 16;
   localparam logic [POSITION_BITS:0] NEWLEN_MAX = (POSITION_BITS + 1)'(
      (64'd1 << POSITION_BITS) - 64'd1 + 64'(REPLACE_MAX));

   logic [7:0]               win_ff [PATTERN_MAX];
   logic [7:0]               win_in [PATTERN_MAX];
   logic [COUNT_BITS-1:0]    pending_ff, pending_in;
   logic [POSITION_BITS:0]   position_ff, position_in;
   logic                     done_ff, done_in;
   logic [POSITION_BITS-1:0] found_ff, found_in;
   logic [POSITION_BITS:0]   emitted_ff, emitted_in;

   logic [COUNT_BITS-1:0]    pat_len, rep_len, seq_len, keep_from, flush_cnt, count;
   logic [7:0]               seq [PATTERN_MAX];
   logic [7:0]               pat [PATTERN_MAX];
   logic                     sfx_ok [PATTERN_MAX];
   logic                     eligible, full_eq, match, closing;
   logic [POSITION_BITS:0]   position_new;
   logic [POSITION_BITS+1:0] emitted_sum;
   logic [POSITION_BITS:0]   emitted_new;
   logic                     done_new;
   logic [POSITION_BITS-1:0] found_new;

   always_comb begin
      priority if (cfg.pattern_length == '0) begin
         pat_len = COUNT_BITS'(1);
      end else if (cfg.pattern_length > COUNT_BITS'(PATTERN_MAX)) begin
         pat_len = COUNT_BITS'(PATTERN_MAX);
      end else begin
         pat_len = cfg.pattern_length;
      end
      if (cfg.replacement_length > COUNT_BITS'(REPLACE_MAX)) begin
         rep_len = COUNT_BITS'(REPLACE_MAX);
      end else begin
         rep_len = cfg.replacement_length;
      end
   end

   // window bytes followed by the new byte
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         seq[i] = (COUNT_BITS'(i) < pending_ff) ? win_ff[i] : req_byte;
         pat[i] = cfg.match_pattern[8*i +: 8];
      end
   end

   assign seq_len  = pending_ff + COUNT_BITS'(1);
   assign eligible = !done_ff && !position_ff[POSITION_BITS] &&
                     (CMP_BITS'(position_ff) >= CMP_BITS'(cfg.start_offset));

   always_comb begin
      full_eq = 1'b1;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (COUNT_BITS'(j) < pat_len && seq[j] != pat[j]) begin
            full_eq = 1'b0;
         end
      end
   end

   assign match = eligible && (seq_len == pat_len) && full_eq;

   // a suffix that still starts the pattern stays in the window
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         sfx_ok[k] = (COUNT_BITS'(k) < seq_len) &&
                     ((seq_len - COUNT_BITS'(k)) < pat_len);
         for (int j = 0; j < PATTERN_MAX; j++) begin
            if (k + j < PATTERN_MAX) begin
               if (COUNT_BITS'(k + j) < seq_len && seq[k + j] != pat[j]) begin
                  sfx_ok[k] = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      keep_from = seq_len;
      for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
         if (sfx_ok[k]) begin
            keep_from = COUNT_BITS'(k);
         end
      end
   end

   always_comb begin
      flush_cnt = (eligible && !req_last) ? keep_from : seq_len;
      count     = match ? rep_len : flush_cnt;
      closing   = 1'b0;
      if (req_last && count == '0) begin
         count   = COUNT_BITS'(1);
         closing = 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < BURST_MAX; i++) begin
         if (match) begin
            next_bytes[i] = cfg.replacement[8*i +: 8];
         end else if (i < PATTERN_MAX) begin
            next_bytes[i] = seq[i];
         end else begin
            next_bytes[i] = '0;
         end
      end
   end

   always_comb begin
      position_new = (position_ff[POSITION_BITS] && position_ff[0]) ?
                     position_ff : position_ff + 1'b1;
      emitted_sum  = (POSITION_BITS + 2)'(emitted_ff) +
                     (POSITION_BITS + 2)'(closing ? '0 : count);
      emitted_new  = (emitted_sum > (POSITION_BITS + 2)'(NEWLEN_MAX)) ?
                     NEWLEN_MAX : emitted_sum[POSITION_BITS:0];
      done_new     = done_ff || match;
      found_new    = match ? position_ff[POSITION_BITS-1:0] -
                             POSITION_BITS'(pat_len - COUNT_BITS'(1)) : found_ff;
   end

   always_comb begin
      next_ctrl.count      = count;
      next_ctrl.final_flag = req_last;
      next_ctrl.closing    = closing;
      next_ctrl.replaced   = done_new;
      next_ctrl.overflow   = position_new[POSITION_BITS] &&
                             (|position_new[POSITION_BITS-1:0]);
      next_position        = done_new ? found_new : '0;
      next_length          = emitted_new;
   end

   always_comb begin
      win_in      = win_ff;
      pending_in  = pending_ff;
      position_in = position_ff;
      done_in     = done_ff;
      found_in    = found_ff;
      emitted_in  = emitted_ff;
      if (advance) begin
         if (req_last) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
               win_in[i] = '0;
            end
            pending_in  = '0;
            position_in = '0;
            done_in     = 1'b0;
            found_in    = '0;
            emitted_in  = '0;
         end else begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
               for (int k = 0; k < PATTERN_MAX; k++) begin
                  if (keep_from == COUNT_BITS'(k) && i + k < PATTERN_MAX) begin
                     win_in[i] = seq[i + k];
                  end
               end
            end
            pending_in  = (match || !eligible) ? '0 : seq_len - keep_from;
            position_in = position_new;
            done_in     = done_new;
            found_in    = found_new;
            emitted_in  = emitted_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            win_ff[i] <= '0;
         end
         pending_ff  <= '0;
         position_ff <= '0;
         done_ff     <= 1'b0;
         found_ff    <= '0;
         emitted_ff  <= '0;
      end else begin
         win_ff      <= win_in;
         pending_ff  <= pending_in;
         position_ff <= position_in;
         done_ff     <= done_in;
         found_ff    <= found_in;
         emitted_ff  <= emitted_in;
      end
   end

   `SFR_ASSERT(a_pending_bound, pending_ff < COUNT_BITS'(PATTERN_MAX), "window overfull")
   `SFR_ASSERT(a_done_empty, done_ff |-> pending_ff == '0, "bytes held after replacement")
   `SFR_ASSERT(a_found_clear, !done_ff |-> found_ff == '0, "match position without match")

endmodule

`default_nettype wire

[sv/sfr_burst.sv]
`default_nettype none
`include "stream_find_replace_first_defines.svh"

module sfr_burst #(
   parameter  int PATTERN_MAX   = sfr_pkg::PATTERN_MAX_DEF,
   parameter  int REPLACE_MAX   = sfr_pkg::REPLACE_MAX_DEF,
   parameter  int POSITION_BITS = sfr_pkg::POSITION_BITS_DEF,
   localparam int BURST_MAX     = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX,
   localparam int RSP_DATA_BITS = ((2 * POSITION_BITS + 11 + 7) / 8) * 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire sfr_pkg::burst_ctrl_type    next_ctrl,
   input  wire logic [7:0]                 next_bytes [BURST_MAX],
   input  wire logic [POSITION_BITS-1:0]   next_position,
   input  wire logic [POSITION_BITS:0]     next_length,
   output logic                            ready,
   output logic      [RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready
);
   import sfr_pkg::*;

   localparam int POS_LSB = 9;
   localparam int LEN_LSB = 9 + POSITION_BITS;
   localparam int OVF_BIT = 10 + 2 * POSITION_BITS;

   burst_ctrl_type           ctrl_ff, ctrl_in;
   logic [7:0]               bytes_ff [BURST_MAX];
   logic [7:0]               bytes_in [BURST_MAX];
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [POSITION_BITS:0]   length_ff, length_in;
   logic                     take, is_tail;

   assign take       = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = ctrl_ff.count != '0;
   assign ready      = (ctrl_ff.count == '0) ||
                       (ctrl_ff.count == COUNT_BITS'(1) && rsp_tready);
   assign is_tail    = ctrl_ff.final_flag && ctrl_ff.count == COUNT_BITS'(1);

   always_comb begin
      ctrl_in     = ctrl_ff;
      bytes_in    = bytes_ff;
      position_in = position_ff;
      length_in   = length_ff;
      priority if (load) begin
         ctrl_in     = next_ctrl;
         bytes_in    = next_bytes;
         position_in = next_position;
         length_in   = next_length;
      end else if (take) begin
         ctrl_in.count = ctrl_ff.count - COUNT_BITS'(1);
         for (int i = 0; i < BURST_MAX - 1; i++) begin
            bytes_in[i] = bytes_ff[i + 1];
         end
         bytes_in[BURST_MAX-1] = '0;
      end
   end

   // tdata: out_byte, replaced, match_position, rewritten_length, overflow, zero pad
   always_comb begin
      rsp_tdata      = '0;
      rsp_tdata[7:0] = ctrl_ff.closing ? 8'h00 : bytes_ff[0];
      if (is_tail) begin
         rsp_tdata[8]                             = ctrl_ff.replaced;
         rsp_tdata[POS_LSB +: POSITION_BITS]      = position_ff;
         rsp_tdata[LEN_LSB +: POSITION_BITS + 1]  = length_ff;
         rsp_tdata[OVF_BIT]                       = ctrl_ff.overflow;
      end
      rsp_tuser = !ctrl_ff.closing;
      rsp_tlast = is_tail;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      position_ff <= position_in;
      length_ff   <= length_in;
   end

   `SFR_ASSERT_ALWAYS(a_reset_empty, reset |=> ctrl_ff.count == '0, "burst not empty after reset")
   `SFR_ASSERT(a_count_range, ctrl_ff.count <= COUNT_BITS'(BURST_MAX), "burst count too large")
   `SFR_ASSERT(a_count_step, (take && !load && ctrl_ff.count > COUNT_BITS'(1)) |=> ctrl_ff.count == $past(ctrl_ff.count) - COUNT_BITS'(1), "burst count did not step")
   `SFR_ASSERT(a_closing_tail, ctrl_ff.closing |-> (ctrl_ff.count <= COUNT_BITS'(1) && ctrl_ff.final_flag), "closing word not at end")

endmodule

`default_nettype wire

[sv/stream_find_replace_first.sv]
// Streaming find-and-replace of the first pattern occurrence in a byte string.
// req: one source byte per word in req_tdata, req_tlast on the final byte.
// rsp: one rewritten byte per word; rsp_tuser low marks a closing word with
//   no byte (the match deleted the string's tail). On the rsp_tlast word the
//   tdata also carries replaced, match_position, rewritten_length and overflow.
// csr: APB-style writes to pattern, lengths, replacement and start offset at
//   byte addresses 0, 8, 16, 24, 32; write only while no string is in flight.
// Latency: the first word of a byte's output is valid the cycle after the
//   byte is accepted.
// Throughput: one byte per cycle while each byte yields one word and rsp_tready
//   is high. A byte that yields n words (window flush or replacement, n up to 8)
//   keeps req_tready low while the output burst register drains one word per
//   cycle, and the next byte enters as its last word leaves.
// Stall: while rsp_tready is low the current word holds and req_tready stays
//   low as long as any word is held.
// Reset: clears the window, counters and the output burst; registers return
//   to pattern length 1, empty replacement, start offset 0. No memory sweep.
`default_nettype none

module stream_find_replace_first #(
   parameter  int PATTERN_MAX   = sfr_pkg::PATTERN_MAX_DEF,
   parameter  int REPLACE_MAX   = sfr_pkg::REPLACE_MAX_DEF,
   parameter  int POSITION_BITS = sfr_pkg::POSITION_BITS_DEF,
   localparam int BURST_MAX     = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX,
   localparam int RSP_DATA_BITS = ((2 * POSITION_BITS + 11 + 7) / 8) * 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // in_byte
   input  wire logic [7:0]                          req_tdata,
   input  wire logic                                req_tlast,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // out_byte, replaced, match_position, rewritten_length, overflow, zero pad
   output logic      [RSP_DATA_BITS-1:0]            rsp_tdata,
   // has_byte
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [sfr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [sfr_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [sfr_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                     csr_pready
);
   import sfr_pkg::*;

   cfg_type                  cfg;
   burst_ctrl_type           next_ctrl;
   logic [7:0]               next_bytes [BURST_MAX];
   logic [POSITION_BITS-1:0] next_position;
   logic [POSITION_BITS:0]   next_length;
   logic                     advance;

   assign advance = req_tvalid && req_tready;

   sfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfr_core #(
      .PATTERN_MAX   (PATTERN_MAX),
      .REPLACE_MAX   (REPLACE_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_byte      (req_tdata),
      .req_last      (req_tlast),
      .advance       (advance),
      .next_ctrl     (next_ctrl),
      .next_bytes    (next_bytes),
      .next_position (next_position),
      .next_length   (next_length)
   );

   sfr_burst #(
      .PATTERN_MAX   (PATTERN_MAX),
      .REPLACE_MAX   (REPLACE_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_burst (
      .clock         (clock),
      .reset         (reset),
      .load          (advance),
      .next_ctrl     (next_ctrl),
      .next_bytes    (next_bytes),
      .next_position (next_position),
      .next_length   (next_length),
      .ready         (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready)
   );

endmodule

`default_nettype wire
